FILE: rtl/hbw_pkg.sv
// ----------------------------------------------------------------------------
// hbw_pkg: shared types and constants for the heartbeat watchdog supervisor
// Word layouts for the request and response channels, configuration and
// supervisor state records, and the codes for kinds, sources and registers.
// ----------------------------------------------------------------------------
package hbw_pkg;

   // number of heartbeat sources
   localparam int NSRC = 3;

   // item kinds
   localparam logic [1:0] KIND_START   = 2'd0;
   localparam logic [1:0] KIND_CHECKIN = 2'd1;
   localparam logic [1:0] KIND_EVAL    = 2'd2;

   // check-in sources
   localparam logic [1:0] SRC_CORE0 = 2'd0;
   localparam logic [1:0] SRC_CORE1 = 2'd1;
   localparam logic [1:0] SRC_FX    = 2'd2;
   localparam logic [1:0] SRC_NONE  = 2'd3;

   // configuration register indexes
   localparam logic [2:0] CSR_TIMEOUT      = 3'd0;
   localparam logic [2:0] CSR_WARN         = 3'd1;
   localparam logic [2:0] CSR_WARN_INTERVAL = 3'd2;
   localparam logic [2:0] CSR_LOW_WATERMARK = 3'd3;
   localparam logic [2:0] CSR_STARVATION   = 3'd4;

   // configuration reset values
   localparam logic [15:0] TIMEOUT_RST       = 16'd4000;
   localparam logic [15:0] WARN_RST          = 16'd1000;
   localparam logic [15:0] WARN_INTERVAL_RST = 16'd1000;
   localparam logic [15:0] LOW_WATERMARK_RST = 16'd2000;
   localparam logic [15:0] STARVATION_RST    = 16'd15000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  source;
      logic [31:0] now_ms;
      logic [15:0] wd_remaining_ms;
   } req_word_type;

   typedef struct packed {
      logic        feed_watchdog;
      logic        warn_slow;
      logic        record_event;
      logic        record_stalled;
      logic        core0_stall_reset;
      logic [31:0] age_core0;
      logic [31:0] age_core1;
      logic [31:0] age_fx;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] timeout_ms;
      logic [15:0] warn_ms;
      logic [15:0] warn_interval_ms;
      logic [15:0] low_watermark_ms;
      logic [15:0] starvation_limit_ms;
   } cfg_type;

   typedef struct packed {
      logic [NSRC-1:0][31:0] checkin_time;
      logic [31:0]           last_warn_time;
      logic                  enabled;
   } sup_state_type;

endpackage

FILE: rtl/hbw_csr.sv
// ----------------------------------------------------------------------------
// hbw_csr: configuration registers
// Five 16-bit threshold registers written through the csr channel.
// ----------------------------------------------------------------------------
module hbw_csr
   import hbw_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  logic [2:0]  wr_index,
   input  logic [15:0] wr_data,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode, unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_TIMEOUT:       cfg_in.timeout_ms          = wr_data;
            CSR_WARN:          cfg_in.warn_ms             = wr_data;
            CSR_WARN_INTERVAL: cfg_in.warn_interval_ms    = wr_data;
            CSR_LOW_WATERMARK: cfg_in.low_watermark_ms    = wr_data;
            CSR_STARVATION:    cfg_in.starvation_limit_ms = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.timeout_ms          <= TIMEOUT_RST;
         cfg_ff.warn_ms             <= WARN_RST;
         cfg_ff.warn_interval_ms    <= WARN_INTERVAL_RST;
         cfg_ff.low_watermark_ms    <= LOW_WATERMARK_RST;
         cfg_ff.starvation_limit_ms <= STARVATION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/hbw_eval.sv
// ----------------------------------------------------------------------------
// hbw_eval: supervisor decision logic
// Computes the response word and the next supervisor state for one item
// from the current state and configuration.
// ----------------------------------------------------------------------------
module hbw_eval
   import hbw_pkg::*;
(
   input  req_word_type  item,
   input  cfg_type       cfg,
   input  sup_state_type state_cur,
   output rsp_word_type  rsp,
   output sup_state_type state_nxt
);

   logic [NSRC-1:0][31:0] stamp_ck;
   logic [NSRC-1:0][31:0] age_ck;
   logic [NSRC-1:0][31:0] age_ev;
   logic [31:0]           since_warn;
   logic                  rate_ok;
   logic                  low_wd;
   logic                  fx_late;
   logic                  c0_starved;
   logic                  any_slow;

   // per-source stamps and ages for check-in and evaluate
   always_comb begin
      for (int i = 0; i < NSRC; i++) begin
         stamp_ck[i] = (item.source == 2'(i)) ? item.now_ms : state_cur.checkin_time[i];
         age_ck[i]   = item.now_ms - stamp_ck[i];
         age_ev[i]   = (item.now_ms > state_cur.checkin_time[i]) ?
                       item.now_ms - state_cur.checkin_time[i] : 32'd0;
      end
   end

   // threshold compares
   assign since_warn = item.now_ms - state_cur.last_warn_time;
   assign rate_ok    = since_warn > {16'd0, cfg.warn_interval_ms};
   assign low_wd     = item.wd_remaining_ms < cfg.low_watermark_ms;
   assign fx_late    = age_ev[SRC_FX] > {16'd0, cfg.timeout_ms};
   assign c0_starved = age_ev[SRC_CORE0] > {16'd0, cfg.starvation_limit_ms};
   assign any_slow   = (age_ev[SRC_CORE0] > {16'd0, cfg.warn_ms}) ||
                       (age_ev[SRC_CORE1] > {16'd0, cfg.warn_ms}) ||
                       (age_ev[SRC_FX]    > {16'd0, cfg.warn_ms});

   // decision per kind
   always_comb begin
      rsp       = '0;
      state_nxt = state_cur;
      case (item.kind)
         KIND_START: begin
            for (int i = 0; i < NSRC; i++) begin
               state_nxt.checkin_time[i] = item.now_ms;
            end
            state_nxt.enabled = 1'b1;
         end
         KIND_CHECKIN: begin
            if (state_cur.enabled) begin
               state_nxt.checkin_time = stamp_ck;
               rsp.age_core0          = age_ck[SRC_CORE0];
               rsp.age_core1          = age_ck[SRC_CORE1];
               rsp.age_fx             = age_ck[SRC_FX];
               if (low_wd && rate_ok) begin
                  state_nxt.last_warn_time = item.now_ms;
                  rsp.record_event         = 1'b1;
               end
            end
         end
         KIND_EVAL: begin
            if (state_cur.enabled) begin
               rsp.age_core0         = age_ev[SRC_CORE0];
               rsp.age_core1         = age_ev[SRC_CORE1];
               rsp.age_fx            = age_ev[SRC_FX];
               rsp.core0_stall_reset = c0_starved;
               if (!fx_late && !c0_starved) begin
                  rsp.feed_watchdog = 1'b1;
                  if (any_slow && rate_ok) begin
                     state_nxt.last_warn_time = item.now_ms;
                     rsp.warn_slow            = 1'b1;
                  end
               end else if (rate_ok) begin
                  state_nxt.last_warn_time = item.now_ms;
                  rsp.record_event         = 1'b1;
                  rsp.record_stalled       = 1'b1;
               end
            end
         end
         default: begin
            rsp       = '0;
            state_nxt = state_cur;
         end
      endcase
   end

endmodule

FILE: rtl/multi_heartbeat_watchdog_supervisor.sv
// ----------------------------------------------------------------------------
// multi_heartbeat_watchdog_supervisor: three-source heartbeat supervisor
// Tracks check-ins of core0, core1 and the effects task and decides on
// watchdog feeding, slowness warnings, health events and core0 reset.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  req_word_type
//   rsp      out        rsp_valid/rsp_stall  rsp_word_type
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// One word per cycle while rsp_stall is low. rsp_valid rises once an accepted
// word moves from the input register through the decision logic into rsp_ff.
// State is updated as a word moves from the input to the response register.
// Synchronous reset restores the threshold defaults and disables the block.
// A stalled response holds; the input register still takes one more word.
// ----------------------------------------------------------------------------
module multi_heartbeat_watchdog_supervisor
   import hbw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata
);

   req_word_type  req_ff;
   logic          req_valid_ff;
   logic          req_valid_in;
   rsp_word_type  rsp_ff;
   logic          rsp_valid_ff;
   logic          rsp_valid_in;
   sup_state_type state_ff;
   sup_state_type state_in;
   rsp_word_type  rsp_in;
   cfg_type       cfg;
   logic          rsp_load;
   logic          advance;
   logic          req_take;

   // configuration registers
   assign csr_ready = 1'b1;

   hbw_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // decision logic
   hbw_eval u_eval (
      .item      (req_ff),
      .cfg       (cfg),
      .state_cur (state_ff),
      .rsp       (rsp_in),
      .state_nxt (state_in)
   );

   // pipeline flow control
   assign rsp_load     = !rsp_valid_ff || !rsp_stall;
   assign advance      = req_valid_ff && rsp_load;
   assign req_stall    = req_valid_ff && !rsp_load;
   assign req_take     = req_valid && !req_stall;
   assign req_valid_in = req_take || (req_valid_ff && !rsp_load);
   assign rsp_valid_in = rsp_load ? req_valid_ff : rsp_valid_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   // a fed watchdog never comes with a core0 reset
   a_feed_no_reset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.feed_watchdog && rsp_data.core0_stall_reset))
      else $error("feed together with core0 reset");

   // warnings only on healthy evaluations
   a_warn_fed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.warn_slow |-> rsp_data.feed_watchdog)
      else $error("warning without feed");

   // stalled kind only on a recorded event
   a_stalled_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.record_stalled |-> rsp_data.record_event)
      else $error("stalled kind without event");

   // a start word enables the block
   a_start_enables: assert property (@(posedge clock) disable iff (reset)
      advance && req_ff.kind == KIND_START |=> state_ff.enabled)
      else $error("start did not enable");
`endif

endmodule

FILE: sim/hbw_supervisor_checker.sv
// ----------------------------------------------------------------------------
// hbw_supervisor_checker: response checker for the heartbeat supervisor
// Watches the request, response and csr channels, keeps its own copy of the
// thresholds and the heartbeat stamps, works out the response word for each
// accepted request word and compares every accepted response word with the
// oldest one still waiting. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module hbw_supervisor_checker
   import hbw_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_data,
   input  logic         csr_valid,
   input  logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_wdata,
   output int           fail_count,
   output int           outstanding
);

   // shadow thresholds and supervisor state
   cfg_type      thr;
   logic [31:0]  stamp [NSRC];
   logic [31:0]  last_alarm;
   logic         armed;

   // response words still owed by the block, oldest first
   rsp_word_type owed_words [$];

   initial begin
      fail_count  = 0;
      outstanding = 0;
   end

   // rate limit: time since the last warning or event must exceed the interval
   function automatic logic spacing_ok(logic [31:0] now);
      logic [31:0] gap;
      gap = now - last_alarm;
      return gap > {16'd0, thr.warn_interval_ms};
   endfunction

   // response word for one request word, with the state update it causes
   function automatic rsp_word_type judge_heartbeats(req_word_type w);
      rsp_word_type r;
      logic [31:0]  age [NSRC];
      logic         healthy;
      logic         slow;
      r = '0;
      for (int i = 0; i < NSRC; i++) age[i] = '0;
      case (w.kind)
         KIND_START: begin
            for (int i = 0; i < NSRC; i++) stamp[i] = w.now_ms;
            armed = 1'b1;
         end
         KIND_CHECKIN: begin
            if (armed) begin
               if (w.source != SRC_NONE) stamp[w.source] = w.now_ms;
               for (int i = 0; i < NSRC; i++) age[i] = w.now_ms - stamp[i];
               if ({16'd0, w.wd_remaining_ms} < {16'd0, thr.low_watermark_ms} &&
                   spacing_ok(w.now_ms)) begin
                  last_alarm     = w.now_ms;
                  r.record_event = 1'b1;
               end
            end
         end
         KIND_EVAL: begin
            if (armed) begin
               // ages floored at zero when a stamp lies ahead of now
               for (int i = 0; i < NSRC; i++)
                  age[i] = (w.now_ms > stamp[i]) ? w.now_ms - stamp[i] : 32'd0;
               healthy = !(age[2] > {16'd0, thr.timeout_ms});
               if (age[0] > {16'd0, thr.starvation_limit_ms}) begin
                  r.core0_stall_reset = 1'b1;
                  healthy             = 1'b0;
               end
               slow = (age[0] > {16'd0, thr.warn_ms}) || (age[1] > {16'd0, thr.warn_ms}) ||
                      (age[2] > {16'd0, thr.warn_ms});
               if (healthy) begin
                  r.feed_watchdog = 1'b1;
                  if (slow && spacing_ok(w.now_ms)) begin
                     last_alarm  = w.now_ms;
                     r.warn_slow = 1'b1;
                  end
               end else if (spacing_ok(w.now_ms)) begin
                  last_alarm       = w.now_ms;
                  r.record_event   = 1'b1;
                  r.record_stalled = 1'b1;
               end
            end
         end
         default: ;
      endcase
      r.age_core0 = age[0];
      r.age_core1 = age[1];
      r.age_fx    = age[2];
      return r;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   // sample all channels at the rising edge
   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         thr = {TIMEOUT_RST, WARN_RST, WARN_INTERVAL_RST, LOW_WATERMARK_RST, STARVATION_RST};
         for (int i = 0; i < NSRC; i++) stamp[i] = '0;
         last_alarm = '0;
         armed      = 1'b0;
         owed_words.delete();
      end else begin
         // response word against the oldest owed word
         if (rsp_valid && !rsp_stall) begin
            if (owed_words.size() == 0) begin
               $error("response word with none owed: %0h", rsp_data);
               fail_count++;
            end else begin
               want = owed_words.pop_front();
               check_field("feed_watchdog", 32'(want.feed_watchdog),
                           32'(rsp_data.feed_watchdog));
               check_field("warn_slow", 32'(want.warn_slow), 32'(rsp_data.warn_slow));
               check_field("record_event", 32'(want.record_event),
                           32'(rsp_data.record_event));
               check_field("record_stalled", 32'(want.record_stalled),
                           32'(rsp_data.record_stalled));
               check_field("core0_stall_reset", 32'(want.core0_stall_reset),
                           32'(rsp_data.core0_stall_reset));
               check_field("age_core0", want.age_core0, rsp_data.age_core0);
               check_field("age_core1", want.age_core1, rsp_data.age_core1);
               check_field("age_fx", want.age_fx, rsp_data.age_fx);
            end
         end
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TIMEOUT:       thr.timeout_ms          = csr_wdata;
               CSR_WARN:          thr.warn_ms             = csr_wdata;
               CSR_WARN_INTERVAL: thr.warn_interval_ms    = csr_wdata;
               CSR_LOW_WATERMARK: thr.low_watermark_ms    = csr_wdata;
               CSR_STARVATION:    thr.starvation_limit_ms = csr_wdata;
               default: ;
            endcase
         end
         // accepted request word
         if (req_valid && !req_stall) owed_words.push_back(judge_heartbeats(req_data));
      end
      outstanding = owed_words.size();
   end

endmodule

FILE: sim/tb_multi_heartbeat_watchdog_supervisor.sv
// ----------------------------------------------------------------------------
// tb_multi_heartbeat_watchdog_supervisor: testbench for the heartbeat supervisor
// Drives a directed set of request words, then random phases of start, check-in,
// evaluate and no-op words under several threshold settings, with random
// gaps on both channels, a long response hold-off and a full drain pause.
// The checker beside the block predicts and compares every response word.
// ----------------------------------------------------------------------------
module tb_multi_heartbeat_watchdog_supervisor;
   import hbw_pkg::*;

   // kind code the block treats as no operation
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam int PHASES       = 6;
   localparam int PHASE_WORDS  = 320;
   localparam int HOLD_CYCLES  = 400;
   localparam int CYCLE_LIMIT  = 400000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [15:0]  csr_wdata;

   int           fail_count;
   int           outstanding;
   int           send_idle;
   int           recv_idle;
   int           hold_left;
   int           cycles;
   logic [31:0]  wall_ms;

   multi_heartbeat_watchdog_supervisor dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   hbw_supervisor_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("multi_heartbeat_watchdog_supervisor verification failed");
            $finish;
         end
      end
   end

   // response side: random stall, or a long hold-off when asked
   initial begin
      rsp_stall = 1'b0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle);
         end
      end
   end

   function automatic req_word_type make_word(logic [1:0] kind, logic [1:0] source,
                                              logic [31:0] now, logic [15:0] wd);
      req_word_type w;
      w.kind            = kind;
      w.source          = source;
      w.now_ms          = now;
      w.wd_remaining_ms = wd;
      return w;
   endfunction

   // random word: time mostly moves forward, sometimes jumps or runs back
   function automatic req_word_type random_word();
      int          r;
      logic [1:0]  kind;
      logic [15:0] wd;
      case ($urandom_range(9))
         0, 1, 2, 3: wall_ms = wall_ms + $urandom_range(0, 300);
         4, 5, 6:    wall_ms = wall_ms + $urandom_range(0, 3000);
         7:          wall_ms = wall_ms + $urandom_range(0, 70000);
         8:          wall_ms = $urandom();
         default:    wall_ms = wall_ms - $urandom_range(0, 2000);
      endcase
      r = $urandom_range(99);
      if (r < 5)       kind = KIND_START;
      else if (r < 8)  kind = KIND_NONE;
      else if (r < 55) kind = KIND_CHECKIN;
      else             kind = KIND_EVAL;
      wd = $urandom_range(1) ? 16'($urandom_range(0, 2500)) : 16'($urandom_range(0, 65535));
      return make_word(kind, 2'($urandom_range(3)), wall_ms, wd);
   endfunction

   // threshold set for each random phase, extremes among them
   function automatic cfg_type phase_config(int phase);
      cfg_type c;
      case (phase)
         0: c = {16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000)),
                 16'($urandom_range(0, 3000))};
         1: c = '0;
         2: c = '1;
         3: c = {16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom())};
         4: c = {TIMEOUT_RST, WARN_RST, WARN_INTERVAL_RST, LOW_WATERMARK_RST, STARVATION_RST};
         default: c = {16'($urandom_range(500, 6000)), 16'($urandom_range(0, 2000)),
                       16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                       16'($urandom_range(2000, 20000))};
      endcase
      return c;
   endfunction

   // offer one request word, called at a falling edge, returns at one
   task automatic send_word(req_word_type w);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // stop offering and wait until every owed response word has come
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   // write all five registers, block idle
   task automatic write_config(cfg_type c);
      logic [2:0]  idx  [5];
      logic [15:0] vals [5];
      idx  = '{CSR_TIMEOUT, CSR_WARN, CSR_WARN_INTERVAL, CSR_LOW_WATERMARK, CSR_STARVATION};
      vals = '{c.timeout_ms, c.warn_ms, c.warn_interval_ms, c.low_watermark_ms,
               c.starvation_limit_ms};
      for (int i = 0; i < 5; i++) begin
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         csr_valid <= 1'b1;
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // stimulus
   initial begin
      req_word_type directed [$];
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle = 11;
      recv_idle = 65;
      wall_ms   = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed words under the reset thresholds
      directed.push_back(make_word(KIND_EVAL, SRC_CORE0, 32'd100, 16'd0));
      directed.push_back(make_word(KIND_CHECKIN, SRC_CORE1, 32'd200, 16'd0));
      directed.push_back(make_word(KIND_NONE, SRC_FX, 32'd300, 16'd0));
      directed.push_back(make_word(KIND_START, SRC_NONE, 32'd1000, 16'hFFFF));
      directed.push_back(make_word(KIND_CHECKIN, SRC_CORE0, 32'd1500, 16'd0));
      directed.push_back(make_word(KIND_CHECKIN, SRC_CORE1, 32'd1600, 16'hFFFF));
      directed.push_back(make_word(KIND_CHECKIN, SRC_FX, 32'd1700, 16'd1999));
      directed.push_back(make_word(KIND_CHECKIN, SRC_NONE, 32'd3000, 16'd1000));
      directed.push_back(make_word(KIND_EVAL, SRC_NONE, 32'd3100, 16'd0));
      directed.push_back(make_word(KIND_EVAL, SRC_CORE0, 32'd4200, 16'd0));
      directed.push_back(make_word(KIND_EVAL, SRC_CORE1, 32'd8000, 16'd0));
      directed.push_back(make_word(KIND_EVAL, SRC_FX, 32'd20000, 16'd0));
      directed.push_back(make_word(KIND_EVAL, SRC_NONE, 32'd500, 16'hFFFF));
      directed.push_back(make_word(KIND_CHECKIN, SRC_NONE, 32'd100, 16'd0));
      directed.push_back(make_word(KIND_START, SRC_CORE0, 32'hFFFF_FF00, 16'd0));
      directed.push_back(make_word(KIND_CHECKIN, SRC_CORE0, 32'h0000_0100, 16'd0));
      directed.push_back(make_word(KIND_EVAL, SRC_NONE, 32'hFFFF_FFFF, 16'd0));
      directed.push_back(make_word(KIND_EVAL, SRC_NONE, 32'h0000_0050, 16'd0));
      directed.push_back(make_word(KIND_START, SRC_NONE, 32'hFFFF_FFFF, 16'hFFFF));
      directed.push_back(make_word(KIND_CHECKIN, SRC_FX, 32'd0, 16'hFFFF));
      directed.push_back(make_word(KIND_NONE, SRC_NONE, 32'hFFFF_FFFF, 16'hFFFF));
      foreach (directed[i]) send_word(directed[i]);

      // random phases: idling pattern changes every two phases
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase / 2)
            0:       begin send_idle = 11; recv_idle = 65; end
            1:       begin send_idle = 65; recv_idle = 11; end
            default: begin send_idle = 0;  recv_idle = 0;  end
         endcase
         drain();
         write_config(phase_config(phase));
         @(negedge clock);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            send_word(random_word());
            // long response hold-off while words keep coming
            if (n == 100) hold_left = HOLD_CYCLES;
            // pause until every owed word is back
            if (n == 200) drain();
         end
      end

      drain();
      repeat (6) @(posedge clock);
      if (fail_count == 0)
         $display("multi_heartbeat_watchdog_supervisor verification clean");
      else
         $display("multi_heartbeat_watchdog_supervisor verification failed");
      $finish;
   end

endmodule
